@@ sv/utf8d_pkg.sv @@
// Shared types and the lead-byte classifier for the UTF-8 byte stream decoder.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package utf8d_pkg;

   // Request word: one raw byte plus the sticky-error clear.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       clear_error;
   } req_type;

   // Response word: one decoded code point.
   typedef struct packed {
      logic [30:0] code_point;
      logic [2:0]  seq_length;
      logic        seq_error;
      logic        error_seen;
      logic        last_of_item;
   } rsp_type;

   // Open-sequence state.
   typedef struct packed {
      logic [30:0] accum_value;
      logic [2:0]  bytes_left;
      logic [2:0]  bytes_taken;
      logic        legacy_form_flag;
   } dec_state_type;

   // Up to two responses produced by one request word.
   typedef struct packed {
      logic [1:0] n_res;
      rsp_type    res0;
      rsp_type    res1;
   } dec_result_type;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_FIVE,
      LEAD_SIX,
      LEAD_BAD
   } lead_class_type;

   localparam logic [7:0] MASK_TWO   = 8'h1F;
   localparam logic [7:0] MASK_THREE = 8'h0F;
   localparam logic [7:0] MASK_FOUR  = 8'h07;
   localparam logic [7:0] MASK_FIVE  = 8'h03;
   localparam logic [7:0] MASK_SIX   = 8'h01;

   function automatic lead_class_type lead_class_f(input logic [7:0] b);
      lead_class_type c;
      case (b) inside
         [8'h00:8'h7F]: c = LEAD_ASCII;
         [8'hC0:8'hDF]: c = LEAD_TWO;
         [8'hE0:8'hEF]: c = LEAD_THREE;
         [8'hF0:8'hF7]: c = LEAD_FOUR;
         [8'hF8:8'hFB]: c = LEAD_FIVE;
         [8'hFC:8'hFD]: c = LEAD_SIX;
         default:       c = LEAD_BAD;   // stray continuation, 0xFE, 0xFF
      endcase
      return c;
   endfunction

endpackage

@@ sv/utf8_byte_stream_decoder.sv @@
// Top level of the UTF-8 byte stream decoder (legacy 5/6-byte forms flagged).
// Depends on utf8d_pkg, utf8d_decode and utf8d_rspq.
`timescale 1ns / 1ps

// Usage
//   req channel: one raw byte per word (req_data.byte_in) plus clear_error,
//     which drops the sticky error flag before that byte is decoded.
//   rsp channel: one decoded code point per word with its byte count, a
//     per-sequence error, the sticky error flag and last_of_item.
//   A byte gives zero, one or two response words. Multi-byte lead and middle
//     continuation bytes give none; a byte that cuts an open sequence gives
//     the flagged partial value and then its own result as a lead byte.
// Timing
//   Each accepted byte is decoded in the cycle it is accepted; its responses
//   are registered into the queue behind any waiting words. One byte per cycle
//   is sustained while rsp_ready is high and each byte gives at most one
//   response. The rate is set by the one-word-per-cycle response port
//   draining the three-entry response queue.
// Reset and stalls
//   Reset closes any open sequence, clears the sticky flag and empties the
//   queue. While rsp_ready is low the queue keeps one spare word plus room
//   for a two-word byte, so req_ready stays high until two words wait.

module utf8_byte_stream_decoder
   import utf8d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dec_state_type  st_ff;
   dec_state_type  st_in;
   logic           sticky_ff;
   logic           sticky_in;
   dec_result_type dec_res;
   dec_result_type push;
   logic           req_accept;

   assign req_accept = req_valid & req_ready;

   utf8d_decode u_decode (
      .st         (st_ff),
      .sticky     (sticky_ff),
      .req        (req_data),
      .st_nxt     (st_in),
      .sticky_nxt (sticky_in),
      .result     (dec_res)
   );

   // only an accepted byte pushes responses
   always_comb begin
      push = dec_res;
      if (!req_accept)
         push.n_res = 2'd0;
   end

   utf8d_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // sequence state advances once per accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= '0;
         sticky_ff <= 1'b0;
      end else if (req_accept) begin
         st_ff     <= st_in;
         sticky_ff <= sticky_in;
      end
   end

   a_pair_starts_cut: assert property (@(posedge clock) disable iff (reset)
      req_accept && dec_res.n_res == 2'd2 |->
         dec_res.res0.seq_error && !dec_res.res0.last_of_item &&
         dec_res.res1.last_of_item)
      else $error("two-word byte not led by a cut sequence");

   a_err_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.seq_error |-> rsp_data.error_seen)
      else $error("sequence error without sticky flag");

   a_open_has_lead: assert property (@(posedge clock) disable iff (reset)
      st_ff.bytes_left != 3'd0 |->
         st_ff.bytes_taken != 3'd0 && st_ff.bytes_taken + st_ff.bytes_left <= 3'd6)
      else $error("open sequence with inconsistent byte counts");

endmodule

@@ sv/utf8d_decode.sv @@
// Single-pass decode of one byte against the open-sequence state.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_decode
   import utf8d_pkg::*;
(
   input  dec_state_type  st,
   input  logic           sticky,
   input  req_type        req,
   output dec_state_type  st_nxt,
   output logic           sticky_nxt,
   output dec_result_type result
);

   logic           s0;
   logic           seq_open;
   logic           is_cont;
   logic           cut;
   logic           lead_emit;
   logic           lead_err;
   logic [30:0]    acc_sh;
   logic [2:0]     taken_inc;
   rsp_type        done_res;
   rsp_type        cut_res;
   rsp_type        lead_res;
   dec_state_type  lead_st;
   lead_class_type lclass;

   always_comb begin
      s0        = sticky & ~req.clear_error;
      seq_open  = (st.bytes_left != 3'd0);
      is_cont   = (req.byte_in[7:6] == 2'b10);
      acc_sh    = {st.accum_value[24:0], req.byte_in[5:0]};
      taken_inc = st.bytes_taken + 3'd1;
      lclass    = lead_class_f(req.byte_in);
      cut       = seq_open & ~is_cont;

      // completed multi-byte sequence
      done_res.code_point   = acc_sh;
      done_res.seq_length   = taken_inc;
      done_res.seq_error    = st.legacy_form_flag;
      done_res.error_seen   = s0 | st.legacy_form_flag;
      done_res.last_of_item = 1'b1;

      // partial value of a cut sequence
      cut_res.code_point   = st.accum_value;
      cut_res.seq_length   = st.bytes_taken;
      cut_res.seq_error    = 1'b1;
      cut_res.error_seen   = 1'b1;
      cut_res.last_of_item = 1'b0;

      // byte taken as a lead
      lead_emit = 1'b0;
      lead_err  = 1'b0;
      lead_st   = '0;
      case (lclass)
         LEAD_ASCII: lead_emit = 1'b1;
         LEAD_TWO:   lead_st = '{31'(req.byte_in & MASK_TWO),   3'd1, 3'd1, 1'b0};
         LEAD_THREE: lead_st = '{31'(req.byte_in & MASK_THREE), 3'd2, 3'd1, 1'b0};
         LEAD_FOUR:  lead_st = '{31'(req.byte_in & MASK_FOUR),  3'd3, 3'd1, 1'b0};
         LEAD_FIVE:  lead_st = '{31'(req.byte_in & MASK_FIVE),  3'd4, 3'd1, 1'b1};
         LEAD_SIX:   lead_st = '{31'(req.byte_in & MASK_SIX),   3'd5, 3'd1, 1'b1};
         default: begin
            lead_emit = 1'b1;
            lead_err  = 1'b1;
         end
      endcase
      lead_res.code_point   = 31'(req.byte_in);
      lead_res.seq_length   = 3'd1;
      lead_res.seq_error    = lead_err;
      lead_res.error_seen   = s0 | cut | lead_err;
      lead_res.last_of_item = 1'b1;

      result = '0;
      if (seq_open && is_cont) begin
         if (st.bytes_left == 3'd1) begin
            st_nxt       = '0;
            sticky_nxt   = s0 | st.legacy_form_flag;
            result.n_res = 2'd1;
            result.res0  = done_res;
         end else begin
            st_nxt             = st;
            st_nxt.accum_value = acc_sh;
            st_nxt.bytes_taken = taken_inc;
            st_nxt.bytes_left  = st.bytes_left - 3'd1;
            sticky_nxt         = s0;
         end
      end else begin
         st_nxt     = lead_st;
         sticky_nxt = s0 | cut | lead_err;
         if (cut && lead_emit) begin
            result.n_res = 2'd2;
            result.res0  = cut_res;
            result.res1  = lead_res;
         end else if (cut) begin
            result.n_res             = 2'd1;
            result.res0              = cut_res;
            result.res0.last_of_item = 1'b1;
         end else if (lead_emit) begin
            result.n_res = 2'd1;
            result.res0  = lead_res;
         end
      end
   end

endmodule

@@ sv/utf8d_rspq.sv @@
// Three-entry response queue; head entry drives the response port.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_rspq
   import utf8d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  dec_result_type push,
   output logic           room,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   rsp_type    q_ff [3];
   rsp_type    q_in [3];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] base;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign room      = (count_ff <= 2'd1);
   assign pop       = rsp_valid & rsp_ready;
   assign base      = count_ff - {1'b0, pop};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_in[i] = (pop && i < 2) ? q_ff[(i < 2) ? i + 1 : i] : q_ff[i];
         if (push.n_res != 2'd0 && 2'(i) == base)
            q_in[i] = push.res0;
         if (push.n_res == 2'd2 && 2'(i) == base + 2'd1)
            q_in[i] = push.res1;
      end
      count_in = base + push.n_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   a_pair_fits: assert property (@(posedge clock) disable iff (reset)
      push.n_res == 2'd2 |-> base <= 2'd1)
      else $error("two responses pushed without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push.n_res == 2'd0 |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count did not drop on pop");

endmodule
